// ----- rtl/patch_layout_address_generator_unit_defines.svh -----
// Assertion macros shared by the patch layout address generator RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef PATCH_LAYOUT_ADDRESS_GENERATOR_UNIT_DEFINES_SVH
`define PATCH_LAYOUT_ADDRESS_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PLAG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define PLAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define PLAG_ASSERT_IMPL(label, ante, cons)

`define PLAG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/plag_pkg.sv -----
// Package for the patch layout address generator: widths, limits,
// register indexes and reset values, and the tile count helper. No dependencies.
package plag_pkg;

  localparam int unsigned AddrW    = 34;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned NcW  = 7;   // channels register
  localparam int unsigned NfW  = 9;   // frames register
  localparam int unsigned NdW  = 11;  // height and width registers
  localparam int unsigned PszW = 3;   // tile size registers

  localparam int unsigned TtW  = 9;   // frame tile counter
  localparam int unsigned ThW  = 10;  // row tile counter
  localparam int unsigned TwW  = 10;  // column tile counter
  localparam int unsigned ChW  = 6;   // channel counter
  localparam int unsigned SubW = 2;   // sub-tile counters

  localparam logic [NcW-1:0]  MaxChannels = 7'd64;
  localparam logic [NdW-1:0]  MaxDim      = 11'd1024;
  localparam logic [PszW-1:0] MaxTile     = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNELS,
    REG_FRAMES,
    REG_HEIGHT,
    REG_WIDTH,
    REG_TILE_FRAMES,
    REG_TILE_ROWS,
    REG_TILE_COLS,
    REG_DIRECTION
  } cfg_reg_e;

  localparam logic [NcW-1:0]  RstChannels   = 7'd16;
  localparam logic [NfW-1:0]  RstFrames     = 9'd21;
  localparam logic [NdW-1:0]  RstHeight     = 11'd60;
  localparam logic [NdW-1:0]  RstWidth      = 11'd104;
  localparam logic [PszW-1:0] RstTileFrames = 3'd1;
  localparam logic [PszW-1:0] RstTileRows   = 3'd2;
  localparam logic [PszW-1:0] RstTileCols   = 3'd2;
  localparam logic            RstDirection  = 1'b0;

  // Number of whole tiles along one axis. The tile size is 0 to 4; division
  // by three uses a reciprocal that is exact for every dimension up to 1024.
  function automatic logic [NdW-1:0] tile_count(logic [NdW-1:0] dim, logic [PszW-1:0] size);
    logic [21:0] prod;
    logic [NdW-1:0] res;
    prod = 22'(dim) * 22'd683;
    case (size)
      3'd1:    res = dim;
      3'd2:    res = dim >> 1;
      3'd3:    res = prod[21:11];
      3'd4:    res = dim >> 2;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/patch_layout_address_generator_unit.sv -----
// Patch layout address generator: walks a channel x frame x row x column
// tensor one element per input transfer and emits its plain-layout and
// patch-layout addresses. Depends on plag_pkg and the defines header.
//
// Input channel: in_valid_i/in_ready_o with restart_i; a set restart bit
// begins the walk at the first element before the address is produced.
// Output channel: out_valid_o/out_ready_i carrying spatial_address_o,
// patch_address_o, valid_res_o and last_o, one result per input transfer.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i; any
// write returns the walk to the first element.
// The rate is one item per cycle while the receiver does not stall. The walk
// counters step in the cycle of the transfer and the plain-layout address
// is built by three multiply-add stages.
// All stages advance together, so when the receiver stalls the whole
// pipeline holds and in_ready_o drops until the output register drains.
// Reset loads the register defaults and clears the walk and the pipeline.
`include "patch_layout_address_generator_unit_defines.svh"

module patch_layout_address_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plag_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [plag_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [plag_pkg::AddrW-1:0]     spatial_address_o,
  output logic [plag_pkg::AddrW-1:0]     patch_address_o,
  output logic                           valid_res_o,
  output logic                           last_o
);
  import plag_pkg::*;

  // Configuration registers.
  logic [NcW-1:0]  chan_reg_q;
  logic [NfW-1:0]  frames_reg_q;
  logic [NdW-1:0]  height_reg_q, width_reg_q;
  logic [PszW-1:0] tf_reg_q, tr_reg_q, tc_reg_q;
  logic            dir_reg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_reg_q   <= RstChannels;
      frames_reg_q <= RstFrames;
      height_reg_q <= RstHeight;
      width_reg_q  <= RstWidth;
      tf_reg_q     <= RstTileFrames;
      tr_reg_q     <= RstTileRows;
      tc_reg_q     <= RstTileCols;
      dir_reg_q    <= RstDirection;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CHANNELS:    chan_reg_q   <= cfg_data_i[NcW-1:0];
        REG_FRAMES:      frames_reg_q <= cfg_data_i[NfW-1:0];
        REG_HEIGHT:      height_reg_q <= cfg_data_i[NdW-1:0];
        REG_WIDTH:       width_reg_q  <= cfg_data_i[NdW-1:0];
        REG_TILE_FRAMES: tf_reg_q     <= cfg_data_i[PszW-1:0];
        REG_TILE_ROWS:   tr_reg_q     <= cfg_data_i[PszW-1:0];
        REG_TILE_COLS:   tc_reg_q     <= cfg_data_i[PszW-1:0];
        REG_DIRECTION:   dir_reg_q    <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  // Saturated settings and tile counts.
  logic [NcW-1:0]  nc;
  logic [NdW-1:0]  nh, nw;
  logic [PszW-1:0] pt, ph, pw;
  logic [NdW-1:0]  tt_n, th_n, tw_n;
  logic            empty;

  assign nc   = (chan_reg_q > MaxChannels) ? MaxChannels : chan_reg_q;
  assign nh   = (height_reg_q > MaxDim) ? MaxDim : height_reg_q;
  assign nw   = (width_reg_q > MaxDim) ? MaxDim : width_reg_q;
  assign pt   = (tf_reg_q > MaxTile) ? MaxTile : tf_reg_q;
  assign ph   = (tr_reg_q > MaxTile) ? MaxTile : tr_reg_q;
  assign pw   = (tc_reg_q > MaxTile) ? MaxTile : tc_reg_q;
  assign tt_n = tile_count(NdW'(frames_reg_q), pt);
  assign th_n = tile_count(nh, ph);
  assign tw_n = tile_count(nw, pw);
  assign empty = (nc == '0) || (tt_n == '0) || (th_n == '0) || (tw_n == '0);

  // Handshake and pipeline enable.
  logic out_valid_q, v1_q, v2_q;
  logic en, accept;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // Walk counters.
  logic [TtW-1:0]   tt_q, tt_d;
  logic [ThW-1:0]   th_q, th_d;
  logic [TwW-1:0]   tw_q, tw_d;
  logic [ChW-1:0]   ch_q, ch_d;
  logic [SubW-1:0]  st_q, st_d, sh_q, sh_d, sw_q, sw_d;
  logic [AddrW-1:0] lin_q, lin_d;

  // Counter values after an optional restart.
  logic [TtW-1:0]   tt_c;
  logic [ThW-1:0]   th_c;
  logic [TwW-1:0]   tw_c;
  logic [ChW-1:0]   ch_c;
  logic [SubW-1:0]  st_c, sh_c, sw_c;
  logic [AddrW-1:0] lin_c;

  assign tt_c  = restart_i ? '0 : tt_q;
  assign th_c  = restart_i ? '0 : th_q;
  assign tw_c  = restart_i ? '0 : tw_q;
  assign ch_c  = restart_i ? '0 : ch_q;
  assign st_c  = restart_i ? '0 : st_q;
  assign sh_c  = restart_i ? '0 : sh_q;
  assign sw_c  = restart_i ? '0 : sw_q;
  assign lin_c = restart_i ? '0 : lin_q;

  logic w_tt, w_th, w_tw, w_ch, w_st, w_sh, w_sw;
  logic i_tt, i_th, i_tw, i_ch, i_st, i_sh, i_sw;
  logic tile_step, is_last;

  assign w_tt = ({2'b0, tt_c} + 11'd1) >= tt_n;
  assign w_th = ({1'b0, th_c} + 11'd1) >= th_n;
  assign w_tw = ({1'b0, tw_c} + 11'd1) >= tw_n;
  assign w_ch = ({1'b0, ch_c} + 7'd1) >= nc;
  assign w_st = ({1'b0, st_c} + 3'd1) >= pt;
  assign w_sh = ({1'b0, sh_c} + 3'd1) >= ph;
  assign w_sw = ({1'b0, sw_c} + 3'd1) >= pw;

  assign is_last = (({2'b0, tt_c} + 11'd1) == tt_n) && (({1'b0, th_c} + 11'd1) == th_n) &&
                   (({1'b0, tw_c} + 11'd1) == tw_n) && (({1'b0, ch_c} + 7'd1) == nc) &&
                   (({1'b0, st_c} + 3'd1) == pt) && (({1'b0, sh_c} + 3'd1) == ph) &&
                   (({1'b0, sw_c} + 3'd1) == pw);

  // Carry chain inside a tile; the channel sits at the fast end when unpatchifying.
  always_comb begin
    if (dir_reg_q) begin
      i_ch      = 1'b1;
      i_sw      = w_ch;
      i_sh      = i_sw && w_sw;
      i_st      = i_sh && w_sh;
      tile_step = i_st && w_st;
    end else begin
      i_sw      = 1'b1;
      i_sh      = w_sw;
      i_st      = i_sh && w_sh;
      i_ch      = i_st && w_st;
      tile_step = i_ch && w_ch;
    end
  end

  assign i_tw = tile_step;
  assign i_th = i_tw && w_tw;
  assign i_tt = i_th && w_th;

  assign tt_d  = i_tt ? (w_tt ? '0 : tt_c + 1'b1) : tt_c;
  assign th_d  = i_th ? (w_th ? '0 : th_c + 1'b1) : th_c;
  assign tw_d  = i_tw ? (w_tw ? '0 : tw_c + 1'b1) : tw_c;
  assign ch_d  = i_ch ? (w_ch ? '0 : ch_c + 1'b1) : ch_c;
  assign st_d  = i_st ? (w_st ? '0 : st_c + 1'b1) : st_c;
  assign sh_d  = i_sh ? (w_sh ? '0 : sh_c + 1'b1) : sh_c;
  assign sw_d  = i_sw ? (w_sw ? '0 : sw_c + 1'b1) : sw_c;
  assign lin_d = lin_c + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tt_q  <= '0;
      th_q  <= '0;
      tw_q  <= '0;
      ch_q  <= '0;
      st_q  <= '0;
      sh_q  <= '0;
      sw_q  <= '0;
      lin_q <= '0;
    end else if (cfg_we_i || (accept && (empty || is_last))) begin
      tt_q  <= '0;
      th_q  <= '0;
      tw_q  <= '0;
      ch_q  <= '0;
      st_q  <= '0;
      sh_q  <= '0;
      sw_q  <= '0;
      lin_q <= '0;
    end else if (accept) begin
      tt_q  <= tt_d;
      th_q  <= th_d;
      tw_q  <= tw_d;
      ch_q  <= ch_d;
      st_q  <= st_d;
      sh_q  <= sh_d;
      sw_q  <= sw_d;
      lin_q <= lin_d;
    end
  end

  // First stage: frame coordinate folded into channel * frames + frame.
  logic [NdW-1:0] f_pos;
  logic [11:0]    r_pos, c_pos;
  logic [15:0]    x1;

  assign f_pos = NdW'(tt_c) * NdW'(pt) + NdW'(st_c);
  assign r_pos = 12'(th_c) * 12'(ph) + 12'(sh_c);
  assign c_pos = 12'(tw_c) * 12'(pw) + 12'(sw_c);
  assign x1    = 16'(ch_c) * 16'(frames_reg_q) + 16'(f_pos);

  logic [15:0]      s1_x1_q;
  logic [11:0]      s1_r_q, s1_c_q, s2_c_q;
  logic [AddrW-1:0] s1_lin_q, s2_lin_q, out_lin_q;
  logic             s1_last_q, s2_last_q, out_last_q;
  logic             s1_vr_q, s2_vr_q, out_vr_q;
  logic [26:0]      x2, s2_x2_q;
  logic [37:0]      x3;
  logic [AddrW-1:0] out_sp_q;

  assign x2 = 27'(s1_x1_q) * 27'(nh) + 27'(s1_r_q);
  assign x3 = 38'(s2_x2_q) * 38'(nw) + 38'(s2_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // An empty walk carries zeros so that both addresses come out as zero.
      s1_x1_q   <= empty ? '0 : x1;
      s1_r_q    <= empty ? '0 : r_pos;
      s1_c_q    <= empty ? '0 : c_pos;
      s1_lin_q  <= empty ? '0 : lin_c;
      s1_last_q <= !empty && is_last;
      s1_vr_q   <= !empty;

      s2_x2_q   <= x2;
      s2_c_q    <= s1_c_q;
      s2_lin_q  <= s1_lin_q;
      s2_last_q <= s1_last_q;
      s2_vr_q   <= s1_vr_q;

      out_sp_q   <= x3[AddrW-1:0];
      out_lin_q  <= s2_lin_q;
      out_last_q <= s2_last_q;
      out_vr_q   <= s2_vr_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign spatial_address_o = out_sp_q;
  assign patch_address_o   = out_lin_q;
  assign valid_res_o       = out_vr_q;
  assign last_o            = out_last_q;

  `PLAG_ASSERT_IMPL(a_last_has_element, out_valid_o && last_o, valid_res_o)
  `PLAG_ASSERT_IMPL(a_empty_is_zero, out_valid_o && !valid_res_o, (spatial_address_o == '0) && (patch_address_o == '0) && !last_o)
  `PLAG_ASSERT_NEXT(a_wrap_clears, accept && (empty || is_last), (lin_q == '0) && (ch_q == '0) && (tt_q == '0))
  `PLAG_ASSERT_IMPL(a_ready_when_drained, !out_valid_q, in_ready_o)
  `PLAG_ASSERT_IMPL(a_sub_col_in_tile, sw_q != '0, {1'b0, sw_q} < pw)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for patch_layout_address_generator_unit: it predicts every
// address pair from its own copy of the walk and the registers, under random flow control.
// Depends on plag_pkg and the generator RTL only.
module tb;
  import plag_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomTicks = 1600;

  // Slots of the walk: channel, position inside the tile, and tile position.
  localparam int unsigned Chan  = 0;
  localparam int unsigned SubF  = 1;
  localparam int unsigned SubR  = 2;
  localparam int unsigned SubC  = 3;
  localparam int unsigned TileF = 4;
  localparam int unsigned TileR = 5;
  localparam int unsigned TileC = 6;

  typedef struct packed {
    logic [AddrW-1:0] spatial;
    logic [AddrW-1:0] patch;
    logic             valid_res;
    logic             last;
  } addr_pair_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                restart = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [AddrW-1:0]    spatial_addr;
  logic [AddrW-1:0]    patch_addr;
  logic                valid_res;
  logic                last_flag;

  logic [CfgDataW-1:0] shadow_regs [8];
  int unsigned         walk_pos [7];
  longint unsigned     patch_index;
  addr_pair_t          expected_addrs [$];
  addr_pair_t          head_pair;
  int unsigned         mismatches = 0;
  int unsigned         ticks_sent = 0;
  int unsigned         cycle_count;
  int unsigned         src_idle_pct = 27;
  int unsigned         sink_idle_pct = 27;

  patch_layout_address_generator_unit u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .restart_i        (restart),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .spatial_address_o(spatial_addr),
    .patch_address_o  (patch_addr),
    .valid_res_o      (valid_res),
    .last_o           (last_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clip(input int unsigned v, input int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void clear_walk();
    foreach (walk_pos[k]) walk_pos[k] = 0;
    patch_index = 0;
  endfunction

  // Address pair for one tick, stepping the walk the way the generator does.
  function automatic addr_pair_t next_element(input logic restart_bit);
    int unsigned     walk_size [7];
    int unsigned     order [7];
    int unsigned     nf, nh, nw;
    longint unsigned chan, frame, row, col, plane;
    logic            no_walk, at_end, carry;
    addr_pair_t      res;
    nf = clip(32'(shadow_regs[REG_FRAMES]), 32'(MaxDim));
    nh = clip(32'(shadow_regs[REG_HEIGHT]), 32'(MaxDim));
    nw = clip(32'(shadow_regs[REG_WIDTH]), 32'(MaxDim));
    walk_size[Chan] = clip(32'(shadow_regs[REG_CHANNELS]), 32'(MaxChannels));
    walk_size[SubF] = clip(32'(shadow_regs[REG_TILE_FRAMES]), 32'(MaxTile));
    walk_size[SubR] = clip(32'(shadow_regs[REG_TILE_ROWS]), 32'(MaxTile));
    walk_size[SubC] = clip(32'(shadow_regs[REG_TILE_COLS]), 32'(MaxTile));
    walk_size[TileF] = (walk_size[SubF] == 0) ? 0 : nf / walk_size[SubF];
    walk_size[TileR] = (walk_size[SubR] == 0) ? 0 : nh / walk_size[SubR];
    walk_size[TileC] = (walk_size[SubC] == 0) ? 0 : nw / walk_size[SubC];
    res = '0;
    if (restart_bit) clear_walk();
    no_walk = 1'b0;
    foreach (walk_size[k]) if (walk_size[k] == 0) no_walk = 1'b1;
    if (no_walk) begin
      clear_walk();
      return res;
    end
    chan = walk_pos[Chan];
    frame = walk_pos[TileF];
    frame = frame * walk_size[SubF] + walk_pos[SubF];
    row = walk_pos[TileR];
    row = row * walk_size[SubR] + walk_pos[SubR];
    col = walk_pos[TileC];
    col = col * walk_size[SubC] + walk_pos[SubC];
    plane = nh;
    plane = plane * nw;
    res.spatial = AddrW'(chan * nf * plane + frame * plane + row * nw + col);
    res.patch = AddrW'(patch_index);
    res.valid_res = 1'b1;
    at_end = 1'b1;
    foreach (walk_pos[k]) if (walk_pos[k] + 1 != walk_size[k]) at_end = 1'b0;
    res.last = at_end;
    if (at_end) begin
      clear_walk();
      return res;
    end
    patch_index = patch_index + 1;
    // Patchify keeps the channel outside the tile; unpatchify steps it fastest.
    if (shadow_regs[REG_DIRECTION][0]) order = '{Chan, SubC, SubR, SubF, TileC, TileR, TileF};
    else order = '{SubC, SubR, SubF, Chan, TileC, TileR, TileF};
    carry = 1'b1;
    foreach (order[k]) begin
      if (carry) begin
        if (walk_pos[order[k]] + 1 >= walk_size[order[k]]) begin
          walk_pos[order[k]] = 0;
        end else begin
          walk_pos[order[k]]++;
          carry = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [AddrW-1:0] want,
                                        input logic [AddrW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_addrs.size() == 0) begin
        $display("%0t: result transfer with no tick outstanding, spatial %0h patch %0h",
                 $time, spatial_addr, patch_addr);
        mismatches++;
      end else begin
        head_pair = expected_addrs.pop_front();
        compare_field("spatial_address", head_pair.spatial, spatial_addr);
        compare_field("patch_address", head_pair.patch, patch_addr);
        compare_field("valid_res", AddrW'(head_pair.valid_res), AddrW'(valid_res));
        compare_field("last", AddrW'(head_pair.last), AddrW'(last_flag));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** patch_layout_address_generator_unit: FAILED **");
    $finish;
  end

  // Offers one tick and returns at the edge where it is transferred. Valid is left
  // high so that back-to-back ticks need no second assignment in the same step.
  task automatic send_tick(input logic restart_bit);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      restart <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    restart <= restart_bit;
    do @(posedge clk); while (!in_ready);
    expected_addrs.push_back(next_element(restart_bit));
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until the pipeline has handed back every result.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    int unsigned w;
    case (idx)
      REG_CHANNELS:          w = NcW;
      REG_FRAMES:            w = NfW;
      REG_HEIGHT, REG_WIDTH: w = NdW;
      REG_DIRECTION:         w = 1;
      default:               w = PszW;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    shadow_regs[idx] = val & CfgDataW'((1 << w) - 1);
    clear_walk();
    cfg_we <= 1'b0;
    cfg_data <= CfgDataW'($urandom);
    @(posedge clk);
  endtask

  task automatic program_tensor(input int unsigned ch, input int unsigned fr,
                                input int unsigned ht, input int unsigned wd,
                                input int unsigned tf, input int unsigned tr,
                                input int unsigned tc, input int unsigned dir);
    write_reg(REG_CHANNELS, CfgDataW'(ch));
    write_reg(REG_FRAMES, CfgDataW'(fr));
    write_reg(REG_HEIGHT, CfgDataW'(ht));
    write_reg(REG_WIDTH, CfgDataW'(wd));
    write_reg(REG_TILE_FRAMES, CfgDataW'(tf));
    write_reg(REG_TILE_ROWS, CfgDataW'(tr));
    write_reg(REG_TILE_COLS, CfgDataW'(tc));
    write_reg(REG_DIRECTION, CfgDataW'(dir));
  endtask

  task automatic test_reset_values();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
  endtask

  task automatic test_empty_walk();
    program_tensor(0, 4, 4, 4, 2, 2, 2, 0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
    write_reg(REG_CHANNELS, 11'd2);
    write_reg(REG_TILE_COLS, 11'd0);
    send_tick(1'b0);
    drain();
    // A dimension smaller than its tile leaves no whole tile.
    write_reg(REG_TILE_COLS, 11'd3);
    write_reg(REG_HEIGHT, 11'd1);
    send_tick(1'b0);
    drain();
  endtask

  task automatic test_oversized_settings();
    program_tensor(127, 511, 2047, 2047, 7, 7, 7, 0);
    repeat (3) send_tick(1'b0);
    drain();
  endtask

  // Four-element walks in both directions; the width remainder is never visited.
  task automatic test_walk_end();
    for (int dir = 0; dir < 2; dir++) begin
      program_tensor(2, 1, 1, 3, 1, 1, 2, dir);
      repeat (5) send_tick(1'b0);
      drain();
    end
  endtask

  task automatic test_restart();
    program_tensor(1, 2, 2, 2, 1, 1, 1, 0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    // Rewriting a register with its current value still restarts the walk.
    write_reg(REG_DIRECTION, 11'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
  endtask

  task automatic test_random_walks();
    int unsigned stop_at, phase, n;
    stop_at = ticks_sent + RandomTicks;
    phase = 0;
    while (ticks_sent < stop_at) begin
      drain();
      n = $urandom_range(20, 120);
      if (phase == 3) begin
        // Channel steps every element here, so the top address bits come into play.
        program_tensor(127, 511, 2047, 2047, 1, 1, 1, 0);
        n = 80;
      end else if ($urandom_range(9) < 2) begin
        program_tensor($urandom_range(127), $urandom_range(511), $urandom_range(2047),
                       $urandom_range(2047), $urandom_range(7), $urandom_range(7),
                       $urandom_range(7), $urandom_range(1));
      end else begin
        program_tensor($urandom_range(1, 3), $urandom_range(1, 5), $urandom_range(1, 6),
                       $urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 4),
                       $urandom_range(1, 4), $urandom_range(1));
      end
      if (phase == 5) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
        n = 200;
      end
      for (int k = 0; k < n; k++) begin
        if (phase == 2 && k == n / 2) drain();
        send_tick($urandom_range(99) < 4);
      end
      src_idle_pct = 27;
      sink_idle_pct = 27;
      phase++;
    end
  endtask

  initial begin
    shadow_regs[REG_CHANNELS]    = CfgDataW'(RstChannels);
    shadow_regs[REG_FRAMES]      = CfgDataW'(RstFrames);
    shadow_regs[REG_HEIGHT]      = CfgDataW'(RstHeight);
    shadow_regs[REG_WIDTH]       = CfgDataW'(RstWidth);
    shadow_regs[REG_TILE_FRAMES] = CfgDataW'(RstTileFrames);
    shadow_regs[REG_TILE_ROWS]   = CfgDataW'(RstTileRows);
    shadow_regs[REG_TILE_COLS]   = CfgDataW'(RstTileCols);
    shadow_regs[REG_DIRECTION]   = CfgDataW'(RstDirection);
    clear_walk();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_empty_walk();
    test_oversized_settings();
    test_walk_end();
    test_restart();
    test_random_walks();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_addrs.size() == 0) begin
      $display("** patch_layout_address_generator_unit: PASSED **");
    end else begin
      $display("** patch_layout_address_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule
